// ----- hw/rtl/mexp_pkg.sv -----
`timescale 1ns / 1ps

package mexp_pkg;

   // internal datapath width; request and response fields stay 32 bits
   localparam int WORD_BITS = 32;
   localparam int FIELD_BITS = 32;
   localparam int CNT_BITS = $clog2(WORD_BITS);

   localparam logic [FIELD_BITS-1:0] MODULUS_RESET = 32'd1000000007;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BASE,
      ST_SQUARE,
      ST_MULT,
      ST_DONE
   } mexp_state_type;

   // command to the bit-serial modular multiplier
   typedef struct packed {
      logic                 start;
      logic [WORD_BITS-1:0] multiplicand;
      logic [WORD_BITS-1:0] multiplier;
   } mexp_mul_cmd_type;

   // status back from the multiplier
   typedef struct packed {
      logic busy;
      logic done;
   } mexp_mul_sts_type;

endpackage

// ----- hw/rtl/mexp_modmul.sv -----
`timescale 1ns / 1ps

// multiplicand * multiplier mod modulus, one multiplier bit per cycle, msb first
module mexp_modmul
   import mexp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  mexp_mul_cmd_type     cmd,
   input  logic [WORD_BITS-1:0] modulus,
   output mexp_mul_sts_type     sts,
   output logic [WORD_BITS-1:0] product
);

   logic [WORD_BITS-1:0] acc_ff, acc_in;
   logic [WORD_BITS-1:0] mcand_ff, mcand_in;
   logic [WORD_BITS-1:0] mplier_ff, mplier_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   logic [WORD_BITS+1:0] sum;
   logic [WORD_BITS+1:0] mod1;
   logic [WORD_BITS+1:0] mod2;
   logic [WORD_BITS+1:0] diff1;
   logic [WORD_BITS+1:0] diff2;
   logic [WORD_BITS-1:0] step;

   // double, add multiplicand on a one bit, then drop 0, 1 or 2 moduli (sum < 3m)
   always_comb begin
      mod1 = {2'b00, modulus};
      mod2 = {1'b0, modulus, 1'b0};
      sum = {1'b0, acc_ff, 1'b0}
         + (mplier_ff[WORD_BITS-1] ? {2'b00, mcand_ff} : '0);
      diff1 = sum - mod1;
      diff2 = sum - mod2;
      if (sum >= mod2) begin
         step = diff2[WORD_BITS-1:0];
      end else if (sum >= mod1) begin
         step = diff1[WORD_BITS-1:0];
      end else begin
         step = sum[WORD_BITS-1:0];
      end
   end

   // next state of the serial loop
   always_comb begin
      acc_in = acc_ff;
      mcand_in = mcand_ff;
      mplier_in = mplier_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         acc_in = '0;
         mcand_in = cmd.multiplicand;
         mplier_in = cmd.multiplier;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = step;
         mplier_in = {mplier_ff[WORD_BITS-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_BITS'(WORD_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      mcand_ff <= mcand_in;
      mplier_ff <= mplier_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign product = acc_ff;

endmodule

// ----- hw/rtl/modular_exponentiation_core.sv -----
`timescale 1ns / 1ps
// channel   ports                               direction  handshake
// req       req_base, req_exponent              in         req_valid / req_stall
// rsp       rsp_power                           out        rsp_valid / rsp_stall
// csr       csr_modulus                         in         csr_valid / csr_ready
//
// one request at a time; each modular product runs through the bit-serial multiplier
// a request costs one base reduction, 32 squarings and one multiply per set exponent bit;
// a zero modulus skips the multiplier and answers zero
// synchronous active-high reset clears control state and sets the modulus to 1000000007
// a finished response waits in an output register while rsp_stall is high

module modular_exponentiation_core
   import mexp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [FIELD_BITS-1:0] req_base,
   input  logic [FIELD_BITS-1:0] req_exponent,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [FIELD_BITS-1:0] rsp_power,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [FIELD_BITS-1:0] csr_modulus
);

   mexp_state_type       state_ff, state_in;
   logic [WORD_BITS-1:0] modulus_ff, modulus_in;
   logic [WORD_BITS-1:0] exp_ff, exp_in;
   logic [WORD_BITS-1:0] base_ff, base_in;
   logic [CNT_BITS-1:0]  bit_ff, bit_in;
   logic                 zero_ff, zero_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [FIELD_BITS-1:0] power_ff, power_in;

   mexp_mul_cmd_type     mul_cmd;
   mexp_mul_sts_type     mul_sts;
   logic [WORD_BITS-1:0] product;
   logic [WORD_BITS-1:0] one_mod;
   logic                 last_bit;

   assign one_mod = (modulus_ff == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);
   assign last_bit = (bit_ff == CNT_BITS'(WORD_BITS - 1));

   mexp_modmul u_modmul (
      .clock   (clock),
      .reset   (reset),
      .cmd     (mul_cmd),
      .modulus (modulus_ff),
      .sts     (mul_sts),
      .product (product)
   );

   // modulus register
   always_comb begin
      modulus_in = modulus_ff;
      if (csr_valid && csr_ready) begin
         modulus_in = WORD_BITS'(csr_modulus);
      end
   end

   // sequencer: reduce base, then square and multiply per exponent bit, msb first; zero modulus skips to done
   always_comb begin
      state_in = state_ff;
      exp_in = exp_ff;
      base_in = base_ff;
      bit_in = bit_ff;
      zero_in = zero_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      power_in = power_ff;
      mul_cmd.start = 1'b0;
      mul_cmd.multiplicand = product;
      mul_cmd.multiplier = product;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               exp_in = WORD_BITS'(req_exponent);
               bit_in = '0;
               zero_in = (modulus_ff == '0);
               if (modulus_ff == '0) begin
                  state_in = ST_DONE;
               end else begin
                  // base mod m as (1 mod m) * base
                  mul_cmd.start = 1'b1;
                  mul_cmd.multiplicand = one_mod;
                  mul_cmd.multiplier = WORD_BITS'(req_base);
                  state_in = ST_BASE;
               end
            end
         end
         ST_BASE: begin
            if (mul_sts.done) begin
               base_in = product;
               mul_cmd.start = 1'b1;
               mul_cmd.multiplicand = one_mod;
               mul_cmd.multiplier = one_mod;
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            if (mul_sts.done) begin
               if (exp_ff[WORD_BITS-1]) begin
                  mul_cmd.start = 1'b1;
                  mul_cmd.multiplier = base_ff;
                  state_in = ST_MULT;
               end else if (last_bit) begin
                  state_in = ST_DONE;
               end else begin
                  exp_in = {exp_ff[WORD_BITS-2:0], 1'b0};
                  bit_in = bit_ff + 1'b1;
                  mul_cmd.start = 1'b1;
               end
            end
         end
         ST_MULT: begin
            if (mul_sts.done) begin
               if (last_bit) begin
                  state_in = ST_DONE;
               end else begin
                  exp_in = {exp_ff[WORD_BITS-2:0], 1'b0};
                  bit_in = bit_ff + 1'b1;
                  mul_cmd.start = 1'b1;
                  state_in = ST_SQUARE;
               end
            end
         end
         ST_DONE: begin
            // hand over once the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               power_in = zero_ff ? '0 : FIELD_BITS'(product);
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         modulus_ff <= WORD_BITS'(MODULUS_RESET);
         rsp_valid_ff <= 1'b0;
         bit_ff <= '0;
      end else begin
         state_ff <= state_in;
         modulus_ff <= modulus_in;
         rsp_valid_ff <= rsp_valid_in;
         bit_ff <= bit_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      exp_ff <= exp_in;
      base_ff <= base_in;
      zero_ff <= zero_in;
      power_ff <= power_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_power = power_ff;
   assign csr_ready = 1'b1;

endmodule

// ----- hw/rtl/mexp_checker.sv -----
`timescale 1ns / 1ps

module mexp_checker
   import mexp_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic [FIELD_BITS-1:0] req_base,
   input logic [FIELD_BITS-1:0] req_exponent,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [FIELD_BITS-1:0] rsp_power
);

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_power))
      else $error("stalled response changed");

   // a stalled request holds
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable({req_base, req_exponent}))
      else $error("stalled request changed");

   // an accepted request keeps the block busy on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted without going busy");

   // a new response only appears out of a request in flight
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response without a request in flight");

   // idle with no response right out of reset
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid && !req_stall)
      else $error("not idle after reset");

endmodule

bind modular_exponentiation_core mexp_checker u_mexp_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .req_base     (req_base),
   .req_exponent (req_exponent),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_power    (rsp_power)
);

// ----- tb/modexp_checker.sv -----
`timescale 1ns / 1ps

module modexp_checker
   import mexp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [FIELD_BITS-1:0] req_base,
   input  logic [FIELD_BITS-1:0] req_exponent,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [FIELD_BITS-1:0] rsp_power,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [FIELD_BITS-1:0] csr_modulus,
   output int                    fail_count,
   output int                    outstanding
);

   // modulus as the block should hold it
   logic [WORD_BITS-1:0]  modulus_copy = WORD_BITS'(MODULUS_RESET);
   logic [FIELD_BITS-1:0] expected_powers[$];

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

   // square-and-multiply over every word bit, exact products at double width
   function automatic logic [FIELD_BITS-1:0] predict_power(
      input logic [WORD_BITS-1:0] m,
      input logic [WORD_BITS-1:0] b,
      input logic [WORD_BITS-1:0] e
   );
      logic [2*WORD_BITS-1:0] wide_m;
      logic [2*WORD_BITS-1:0] reduced_base;
      logic [2*WORD_BITS-1:0] acc;
      int i;
      if (m == '0) return '0;
      wide_m       = {{WORD_BITS{1'b0}}, m};
      reduced_base = {{WORD_BITS{1'b0}}, b} % wide_m;
      acc          = (2*WORD_BITS)'(1) % wide_m;
      for (i = WORD_BITS - 1; i >= 0; i--) begin
         acc = (acc * acc) % wide_m;
         if (e[i]) acc = (acc * reduced_base) % wide_m;
      end
      return acc[FIELD_BITS-1:0];
   endfunction

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t ns: %s", $time, what);
      fail_count++;
   endtask

   // track configuration, predict on each request, compare each response
   always @(posedge clock) begin
      logic [FIELD_BITS-1:0] want;
      if (reset) begin
         modulus_copy = WORD_BITS'(MODULUS_RESET);
         expected_powers.delete();
         outstanding <= 0;
      end else begin
         if (csr_valid && csr_ready) modulus_copy = WORD_BITS'(csr_modulus);
         if (rsp_valid && !rsp_stall) begin
            if (expected_powers.size() == 0) begin
               report_mismatch($sformatf("response power=%0h with no request pending",
                                         rsp_power));
            end else begin
               want = expected_powers.pop_front();
               if (rsp_power !== want)
                  report_mismatch($sformatf("power got %0h, want %0h", rsp_power, want));
            end
         end
         if (req_valid && !req_stall)
            expected_powers.push_back(predict_power(modulus_copy, WORD_BITS'(req_base),
                                                    WORD_BITS'(req_exponent)));
         outstanding <= outstanding + int'(req_valid && !req_stall)
                                    - int'(rsp_valid && !rsp_stall);
      end
   end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
   import mexp_pkg::*;

   localparam int HALF_PERIOD  = 10;
   localparam int QUIET_LIMIT  = 20000;
   localparam int RANDOM_ITEMS = 280;
   localparam int PHASE_ITEMS  = 40;
   localparam int IDLE_PERCENT = 25;
   localparam int DRAIN_CYCLES = 50;

   logic                  clock        = 1'b0;
   logic                  reset        = 1'b1;
   logic                  req_valid    = 1'b0;
   logic                  req_stall;
   logic [FIELD_BITS-1:0] req_base     = '0;
   logic [FIELD_BITS-1:0] req_exponent = '0;
   logic                  rsp_valid;
   logic                  rsp_stall    = 1'b0;
   logic [FIELD_BITS-1:0] rsp_power;
   logic                  csr_valid    = 1'b0;
   logic                  csr_ready;
   logic [FIELD_BITS-1:0] csr_modulus  = '0;
   logic                  idle_on      = 1'b1;
   int                    fail_count;
   int                    outstanding;
   int                    quiet_cycles = 0;

   always #HALF_PERIOD clock = ~clock;

   modular_exponentiation_core i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_base     (req_base),
      .req_exponent (req_exponent),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_power    (rsp_power),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_modulus  (csr_modulus)
   );

   modexp_checker i_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_base     (req_base),
      .req_exponent (req_exponent),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_power    (rsp_power),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_modulus  (csr_modulus),
      .fail_count   (fail_count),
      .outstanding  (outstanding)
   );

   // random back-pressure on the response side
   always @(posedge clock) begin
      rsp_stall <= idle_on && ($urandom_range(0, 99) < IDLE_PERCENT);
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
         $display("Test completed with failures");
         $finish;
      end
   end

   // present one request, with optional idle cycles ahead of it
   task automatic send_request(input logic [FIELD_BITS-1:0] b, input logic [FIELD_BITS-1:0] e);
      while (idle_on && ($urandom_range(0, 99) < IDLE_PERCENT)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_base     <= b;
      req_exponent <= e;
      do @(posedge clock); while (req_stall);
   endtask

   // hold off requests until every response is back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic write_modulus(input logic [FIELD_BITS-1:0] value);
      wait_for_results();
      csr_valid   <= 1'b1;
      csr_modulus <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [FIELD_BITS-1:0] pick_modulus();
      case ($urandom_range(0, 5))
         0: return $urandom_range(2, 1000);
         1: return 32'hFFFF_FFFF - $urandom_range(0, 1000);
         2: return 32'd1 << $urandom_range(0, 31);
         3: return 32'd1;
         default: return $urandom | 32'd1;
      endcase
   endfunction

   function automatic logic [FIELD_BITS-1:0] pick_base(input logic [FIELD_BITS-1:0] m);
      case ($urandom_range(0, 7))
         0: return '0;
         1: return m - 32'd1;
         2: return m;
         3: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [FIELD_BITS-1:0] pick_exponent();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return $urandom_range(1, 16);
         2: return 32'hFFFF_FFFF;
         3: return 32'd1 << $urandom_range(0, 31);
         default: return $urandom;
      endcase
   endfunction

   initial begin
      int n;
      logic [FIELD_BITS-1:0] m;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset modulus, zero exponent, field extremes
      send_request(32'd0, 32'd0);
      send_request(32'd5, 32'd0);
      send_request(32'd2, 32'd10);
      send_request(32'd0, 32'd5);
      send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(32'd1, 32'hFFFF_FFFF);
      send_request(32'hFFFF_FFFF, 32'd1);

      // modulus of one gives zero everywhere
      write_modulus(32'd1);
      send_request(32'd7, 32'd0);
      send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(32'd3, 32'd5);

      // zero modulus, no reduction possible
      write_modulus(32'd0);
      send_request(32'd9, 32'd9);
      send_request(32'd0, 32'd0);

      // largest modulus, base equal to modulus reduces to zero
      write_modulus(32'hFFFF_FFFF);
      send_request(32'hFFFF_FFFE, 32'hFFFF_FFFF);
      send_request(32'hFFFF_FFFF, 32'd3);
      send_request(32'h1234_5678, 32'd0);
      send_request(32'd2, 32'd31);

      write_modulus(32'd2);
      send_request(32'd3, 32'd7);
      send_request(32'd4, 32'd1);

      write_modulus(32'h8000_0000);
      send_request(32'd3, 32'hFFFF_FFFF);
      send_request(32'hFFFF_FFFF, 32'd2);

      // random phases, each under its own modulus; two phases run without idling
      m = '0;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % PHASE_ITEMS == 0) begin
            idle_on <= !((n / PHASE_ITEMS == 3) || (n / PHASE_ITEMS == 4));
            m = (n == 0) ? MODULUS_RESET : pick_modulus();
            write_modulus(m);
         end else if (n % PHASE_ITEMS == PHASE_ITEMS / 2) begin
            wait_for_results();
         end
         send_request(pick_base(m), pick_exponent());
      end
      req_valid <= 1'b0;

      // drain, then a few quiet cycles
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/mexp_pkg.sv
hw/rtl/mexp_modmul.sv
hw/rtl/modular_exponentiation_core.sv
hw/rtl/mexp_checker.sv
tb/modexp_checker.sv
tb/testbench.sv
